// File: rtl/skl_pkg.sv
package skl_pkg;

    localparam int MAX_K_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int K_W       = 5;
    localparam int HELD_W    = 5;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 40;
    localparam int M_PAD_W   = M_DATA_W - VALUE_W - HELD_W;
    localparam logic [K_W-1:0] K_RESET = K_W'(1);

    typedef logic signed [VALUE_W-1:0] value_t;

endpackage

// File: rtl/streaming_kth_largest.sv
// Channel   | Dir | Data                                         | Accepted when
// s_axis    | in  | tdata[31:0] value                            | s_axis_tvalid & s_axis_tready
// m_axis    | out | tdata[31:0] kth_largest, [36:32] held_count  | m_axis_tvalid & m_axis_tready
// cfg       | in  | cfg_data[4:0] k_value                        | cfg_valid & cfg_ready
//
// One item per cycle while the output is not stalled; a result appears in the cycle after its item is accepted.
// The sorted store is a row of MAX_K registers updated by parallel compare-and-shift
// in the cycle of acceptance, so the rate is set by that single compare/mux layer.
// Reset empties the store (count zero) and sets k_value to 1; entries need no clearing.
// A stalled result holds in the output register while the next item is still taken
// when the output register drains in the same cycle.
module streaming_kth_largest #(
    parameter int MAX_K = skl_pkg::MAX_K_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [skl_pkg::S_DATA_W-1:0]  s_axis_tdata,   // [31:0] value
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [skl_pkg::M_DATA_W-1:0]  m_axis_tdata,   // [31:0] kth_largest, [36:32] held_count
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [skl_pkg::K_W-1:0]       cfg_data        // [4:0] k_value
);
    import skl_pkg::*;

    localparam int CW = $clog2(MAX_K + 1);
    localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    logic [K_W-1:0]    k_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    value_t            entry_reg  [MAX_K];
    value_t            entry_next [MAX_K];
    logic [MAX_K-1:0]  ge;
    value_t            in_value;
    value_t            kth_reg;
    value_t            kth_next;
    logic [HELD_W-1:0] held_reg;
    logic              valid_reg;
    logic              accept;
    logic [IW-1:0]     tail_idx;
    int                keff;
    int                n_int;

    assign in_value      = value_t'(s_axis_tdata[VALUE_W-1:0]);
    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, held_reg, kth_reg};

    // Entries at or above the new value stay; the new value lands at the first
    // slot that is not, and everything below moves down one slot.
    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            ge[i] = (int'(count_reg) > i) && (entry_reg[i] >= in_value);
        end
        for (int i = 0; i < MAX_K; i++)
        begin
            if (ge[i])
            begin
                entry_next[i] = entry_reg[i];
            end
            else if (i == 0)
            begin
                entry_next[i] = in_value;
            end
            else if (ge[(i > 0) ? i - 1 : 0])
            begin
                entry_next[i] = in_value;
            end
            else
            begin
                entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_comb
    begin
        keff = int'(k_reg);
        if (keff < 1)
        begin
            keff = 1;
        end
        if (keff > MAX_K)
        begin
            keff = MAX_K;
        end
        n_int = int'(count_reg) + 1;
        if (n_int > keff)
        begin
            n_int = keff;
        end
        count_next = CW'(n_int);
        tail_idx   = IW'(n_int - 1);
        kth_next   = entry_next[tail_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= K_RESET;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                k_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_K; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
            kth_reg  <= kth_next;
            held_reg <= HELD_W'(n_int);
        end
    end

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    a_result_store_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (count_reg != '0))
        else $error("result pending with empty store");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_K)
        else $error("entry count exceeds store depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without an item");

endmodule
